FILE: sv/uart_rb_pkg.sv
`default_nettype none
package uart_rb_pkg;

   typedef enum logic [2:0] {
      FUNC_READ   = 3'd0,
      FUNC_WRITE  = 3'd1,
      FUNC_RX     = 3'd2,
      FUNC_TX     = 3'd3,
      FUNC_MODEM  = 3'd4,
      FUNC_TICK   = 3'd5,
      FUNC_NOP6   = 3'd6,
      FUNC_NOP7   = 3'd7
   } func_type;

   localparam logic [2:0] REG_DATA = 3'd0;
   localparam logic [2:0] REG_IER  = 3'd1;
   localparam logic [2:0] REG_IIR  = 3'd2;
   localparam logic [2:0] REG_LCR  = 3'd3;
   localparam logic [2:0] REG_MCR  = 3'd4;
   localparam logic [2:0] REG_LSR  = 3'd5;
   localparam logic [2:0] REG_MSR  = 3'd6;
   localparam logic [2:0] REG_SCR  = 3'd7;

   localparam logic [3:0] IIR_NONE = 4'h1;
   localparam logic [3:0] IIR_RLS  = 4'h6;
   localparam logic [3:0] IIR_RDA  = 4'h4;
   localparam logic [3:0] IIR_CTO  = 4'hC;
   localparam logic [3:0] IIR_THRE = 4'h2;
   localparam logic [3:0] IIR_MSR  = 4'h0;

   // line flag bits
   localparam int LF_OE      = 0;
   localparam int LF_TIMEOUT = 4;
   localparam int LF_THRE    = 5;

   localparam logic [2:0] TIMEOUT_CHARS = 3'd4;

endpackage
`default_nettype wire

FILE: sv/uart_register_block_fifo.sv
`default_nettype none
// 16550-style UART register file with receive and transmit FIFOs. Each request
// is a bus read or write, a received character, a transmit slot, a modem line
// sample or a character-time tick; every request gives one response carrying
// read data, the byte sent to the line, the interrupt line and the current
// line and modem settings. One request is taken per clock while rsp_stall is
// low: the FIFO ends and registers update when a request is accepted, and the
// response sits in an output register, valid in the cycle after the request
// is taken.
module uart_register_block_fifo
   import uart_rb_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [2:0]  req_addr,
   input  wire logic [7:0]  req_wdata,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_rx_parity_error,
   input  wire logic        req_rx_framing_error,
   input  wire logic        req_rx_break,
   input  wire logic        req_cts_in,
   input  wire logic        req_dsr_in,
   input  wire logic        req_ri_in,
   input  wire logic        req_dcd_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_irq,
   output logic             rsp_dtr_out,
   output logic             rsp_rts_out,
   output logic             rsp_out1_out,
   output logic             rsp_out2_out,
   output logic             rsp_break_out,
   output logic [5:0]       rsp_line_format,
   output logic [15:0]      rsp_divisor,
   output logic             rsp_loopback
);

   localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

   logic [10:0] rx_mem [FIFO_DEPTH];
   logic [7:0]  tx_mem [FIFO_DEPTH];

   logic [CW-1:0] rx_count_ff, rx_count_in, tx_count_ff, tx_count_in;
   logic [CW-1:0] err_count_ff, err_count_in;
   logic [PW-1:0] rx_head_ff, rx_head_in, tx_head_ff, tx_head_in;
   logic [3:0]    ier_ff, ier_in;
   logic [7:0]    lcr_ff, lcr_in;
   logic [4:0]    mcr_ff, mcr_in;
   logic [7:0]    msr_ff, msr_in;
   logic [7:0]    scr_ff, scr_in;
   logic [15:0]   dl_ff, dl_in;
   logic [2:0]    fcr_ff, fcr_in;
   logic [5:0]    lf_ff, lf_in;
   logic [3:0]    ext_ff, ext_in;
   logic [2:0]    idle_ff, idle_in;
   logic          busy_ff, busy_in;

   logic          rx_we, tx_we;
   logic [PW-1:0] rx_waddr, tx_waddr;
   logic [10:0]   rx_wdata;
   logic [7:0]    tx_wdata;
   logic [10:0]   rx_head_entry, rx_next_entry;
   logic [7:0]    tx_head_byte;

   logic          rsp_valid_ff;
   logic [7:0]    rd_ff, rd_in, txb_ff, txb_in;
   logic          txv_ff, txv_in;
   logic          accept;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      next_ptr = (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] tail_ptr(input logic [PW-1:0] h,
                                              input logic [CW-1:0] c);
      logic [CW:0] s;
      s = (CW+1)'(h) + (CW+1)'(c);
      if (s >= (CW+1)'(FIFO_DEPTH)) s = s - (CW+1)'(FIFO_DEPTH);
      tail_ptr = s[PW-1:0];
   endfunction

   function automatic logic [3:0] int_source(input logic [3:0] ier,
                                             input logic [5:0] lf,
                                             input logic [CW-1:0] rxc,
                                             input logic [2:0] fcr,
                                             input logic [7:0] msr);
      logic [CW:0] trig;
      case (fcr[2:1])
         2'd0:    trig = (CW+1)'(1);
         2'd1:    trig = (CW+1)'(4);
         2'd2:    trig = (CW+1)'(8);
         default: trig = (CW+1)'(14);
      endcase
      if (trig > (CW+1)'(FIFO_DEPTH)) trig = (CW+1)'(FIFO_DEPTH);
      if (!fcr[0]) trig = (CW+1)'(1);
      if (ier[2] && (lf[3:0] != 4'd0))                      int_source = IIR_RLS;
      else if (ier[0] && ((CW+1)'(rxc) >= trig))            int_source = IIR_RDA;
      else if (ier[0] && lf[LF_TIMEOUT])                    int_source = IIR_CTO;
      else if (ier[1] && lf[LF_THRE])                       int_source = IIR_THRE;
      else if (ier[3] && (msr[3:0] != 4'd0))                int_source = IIR_MSR;
      else                                                  int_source = IIR_NONE;
   endfunction

   assign rx_head_entry = rx_mem[rx_head_ff];
   assign rx_next_entry = rx_mem[next_ptr(rx_head_ff)];
   assign tx_head_byte  = tx_mem[tx_head_ff];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      logic       push;
      logic [10:0] e;
      logic       apply;
      logic       fon;
      logic       dlab;
      logic [3:0] src, old, chg, d, isrc;
      logic [7:0] lsr;
      logic [2:0] errs;

      rx_count_in  = rx_count_ff;
      tx_count_in  = tx_count_ff;
      err_count_in = err_count_ff;
      rx_head_in   = rx_head_ff;
      tx_head_in   = tx_head_ff;
      ier_in = ier_ff;  lcr_in = lcr_ff;  mcr_in = mcr_ff;  msr_in = msr_ff;
      scr_in = scr_ff;  dl_in = dl_ff;    fcr_in = fcr_ff;  lf_in = lf_ff;
      ext_in = ext_ff;  idle_in = idle_ff; busy_in = busy_ff;
      rx_we = 1'b0; rx_waddr = '0; rx_wdata = '0;
      tx_we = 1'b0; tx_waddr = '0; tx_wdata = '0;
      rd_in = '0; txv_in = 1'b0; txb_in = '0;
      push = 1'b0; e = '0; apply = 1'b0;
      src = '0; old = '0; chg = '0; d = '0; lsr = '0; errs = '0;
      fon  = fcr_ff[0];
      dlab = lcr_ff[7];
      isrc = int_source(ier_ff, lf_ff, rx_count_ff, fcr_ff, msr_ff);

      unique case (func_type'(req_func))
         FUNC_READ: begin
            unique case (req_addr)
               REG_DATA: begin
                  if (dlab) begin
                     rd_in = dl_ff[7:0];
                  end else begin
                     if (rx_count_ff != '0) begin
                        rd_in = rx_head_entry[7:0];
                        rx_head_in = next_ptr(rx_head_ff);
                        rx_count_in = rx_count_ff - CW'(1);
                        if (rx_head_entry[10:8] != 3'd0)
                           err_count_in = err_count_ff - CW'(1);
                        if (rx_count_in != '0)
                           lf_in[3:1] = lf_in[3:1] | rx_next_entry[10:8];
                     end
                     idle_in = '0;
                     lf_in[LF_TIMEOUT] = 1'b0;
                  end
               end
               REG_IER: rd_in = dlab ? dl_ff[15:8] : {4'd0, ier_ff};
               REG_IIR: begin
                  rd_in = {fon, fon, 2'd0, isrc};
                  if (isrc == IIR_THRE) lf_in[LF_THRE] = 1'b0;
               end
               REG_LCR: rd_in = lcr_ff;
               REG_MCR: rd_in = {3'd0, mcr_ff};
               REG_LSR: begin
                  lsr[0] = (rx_count_ff != '0);
                  lsr[4:1] = lf_ff[3:0];
                  lsr[5] = (tx_count_ff == '0);
                  lsr[6] = (tx_count_ff == '0) && !busy_ff;
                  lsr[7] = fon && (err_count_ff != '0);
                  rd_in = lsr;
                  lf_in[3:0] = 4'd0;
               end
               REG_MSR: begin
                  rd_in = msr_ff;
                  msr_in = {msr_ff[7:4], 4'd0};
               end
               default: rd_in = scr_ff;
            endcase
         end
         FUNC_WRITE: begin
            unique case (req_addr)
               REG_DATA: begin
                  if (dlab) begin
                     dl_in[7:0] = req_wdata;
                  end else begin
                     if (!fon && (tx_count_ff != '0)) begin
                        tx_we = 1'b1; tx_waddr = tx_head_ff; tx_wdata = req_wdata;
                     end else if (tx_count_ff < DEPTH_C) begin
                        tx_we = 1'b1;
                        tx_waddr = tail_ptr(tx_head_ff, tx_count_ff);
                        tx_wdata = req_wdata;
                        tx_count_in = tx_count_ff + CW'(1);
                     end
                     lf_in[LF_THRE] = 1'b0;
                  end
               end
               REG_IER: begin
                  if (dlab) begin
                     dl_in[15:8] = req_wdata;
                  end else begin
                     if (req_wdata[1] && !ier_ff[1] && (tx_count_ff == '0))
                        lf_in[LF_THRE] = 1'b1;
                     ier_in = req_wdata[3:0];
                  end
               end
               REG_IIR: begin
                  if (req_wdata[0] != fon || (req_wdata[0] && req_wdata[1])) begin
                     rx_count_in = '0; rx_head_in = '0; idle_in = '0;
                     err_count_in = '0; lf_in[LF_TIMEOUT] = 1'b0;
                  end
                  if (req_wdata[0] != fon || (req_wdata[0] && req_wdata[2])) begin
                     if (tx_count_ff != '0) lf_in[LF_THRE] = 1'b1;
                     tx_count_in = '0; tx_head_in = '0;
                  end
                  if (req_wdata[0]) fcr_in = {req_wdata[7:6], 1'b1};
                  else              fcr_in = {fcr_ff[2:1], 1'b0};
               end
               REG_LCR: lcr_in = req_wdata;
               REG_MCR: begin
                  mcr_in = req_wdata[4:0];
                  apply = 1'b1;
               end
               REG_SCR: scr_in = req_wdata;
               default: ;
            endcase
         end
         FUNC_RX: begin
            if (!mcr_ff[4]) begin
               push = 1'b1;
               errs = {req_rx_break, req_rx_framing_error, req_rx_parity_error};
               e = {errs, req_rx_break ? 8'd0 : req_rx_byte};
            end
         end
         FUNC_TX: begin
            if (tx_count_ff != '0) begin
               tx_head_in = next_ptr(tx_head_ff);
               tx_count_in = tx_count_ff - CW'(1);
               if (tx_count_in == '0) lf_in[LF_THRE] = 1'b1;
               busy_in = 1'b1;
               if (mcr_ff[4]) begin
                  push = 1'b1;
                  e = {3'd0, tx_head_byte};
               end else begin
                  txv_in = 1'b1;
                  txb_in = tx_head_byte;
               end
            end else begin
               busy_in = 1'b0;
            end
         end
         FUNC_MODEM: begin
            ext_in = {req_dcd_in, req_ri_in, req_dsr_in, req_cts_in};
            apply = 1'b1;
         end
         FUNC_TICK: begin
            if (fon && (rx_count_ff != '0) && !lf_ff[LF_TIMEOUT]) begin
               idle_in = idle_ff + 3'd1;
               if (idle_in >= TIMEOUT_CHARS) begin
                  idle_in = TIMEOUT_CHARS;
                  lf_in[LF_TIMEOUT] = 1'b1;
               end
            end
         end
         default: ;
      endcase

      if (push) begin
         idle_in = '0;
         lf_in[LF_TIMEOUT] = 1'b0;
         if (rx_count_ff == '0) begin
            rx_we = 1'b1; rx_waddr = rx_head_ff; rx_wdata = e;
            rx_count_in = CW'(1);
            if (e[10:8] != 3'd0) err_count_in = CW'(1);
            lf_in[3:1] = lf_in[3:1] | e[10:8];
         end else if (rx_count_ff < (fon ? DEPTH_C : CW'(1))) begin
            rx_we = 1'b1; rx_waddr = tail_ptr(rx_head_ff, rx_count_ff); rx_wdata = e;
            rx_count_in = rx_count_ff + CW'(1);
            if (e[10:8] != 3'd0) err_count_in = err_count_ff + CW'(1);
         end else begin
            lf_in[LF_OE] = 1'b1;
            if (!fon) begin
               rx_we = 1'b1; rx_waddr = rx_head_ff; rx_wdata = e;
               err_count_in = (e[10:8] != 3'd0) ? CW'(1) : '0;
               lf_in[3:1] = lf_in[3:1] | e[10:8];
            end
         end
      end

      if (apply) begin
         if (mcr_in[4]) src = {mcr_in[3], mcr_in[2], mcr_in[0], mcr_in[1]};
         else           src = ext_in;
         old = msr_in[7:4];
         chg = old ^ src;
         d = msr_in[3:0] | (chg & 4'hB) | (old & ~src & 4'h4);
         msr_in = {src, d};
      end
   end

   always_ff @(posedge clock) begin
      if (accept && rx_we) rx_mem[rx_waddr] <= rx_wdata;
      if (accept && tx_we) tx_mem[tx_waddr] <= tx_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff <= '0; tx_count_ff <= '0; err_count_ff <= '0;
         rx_head_ff <= '0; tx_head_ff <= '0;
         ier_ff <= '0; lcr_ff <= '0; mcr_ff <= '0; msr_ff <= '0;
         scr_ff <= '0; dl_ff <= '0; fcr_ff <= '0; lf_ff <= '0;
         ext_ff <= '0; idle_ff <= '0; busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            rx_count_ff <= rx_count_in; tx_count_ff <= tx_count_in;
            err_count_ff <= err_count_in;
            rx_head_ff <= rx_head_in; tx_head_ff <= tx_head_in;
            ier_ff <= ier_in; lcr_ff <= lcr_in; mcr_ff <= mcr_in; msr_ff <= msr_in;
            scr_ff <= scr_in; dl_ff <= dl_in; fcr_ff <= fcr_in; lf_ff <= lf_in;
            ext_ff <= ext_in; idle_ff <= idle_in; busy_ff <= busy_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff  <= rd_in;
         txv_ff <= txv_in;
         txb_ff <= txb_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rd_ff;
   assign rsp_tx_valid    = txv_ff;
   assign rsp_tx_byte     = txb_ff;
   assign rsp_irq         = mcr_ff[3] &&
                            (int_source(ier_ff, lf_ff, rx_count_ff, fcr_ff, msr_ff) != IIR_NONE);
   assign rsp_dtr_out     = !mcr_ff[4] && mcr_ff[0];
   assign rsp_rts_out     = !mcr_ff[4] && mcr_ff[1];
   assign rsp_out1_out    = !mcr_ff[4] && mcr_ff[2];
   assign rsp_out2_out    = !mcr_ff[4] && mcr_ff[3];
   assign rsp_break_out   = !mcr_ff[4] && lcr_ff[6];
   assign rsp_line_format = lcr_ff[5:0];
   assign rsp_divisor     = dl_ff;
   assign rsp_loopback    = mcr_ff[4];

`ifndef SYNTH
   a_rx_count_range: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= DEPTH_C && tx_count_ff <= DEPTH_C)
      else $error("fifo count beyond depth");
   a_err_count_le: assert property (@(posedge clock) disable iff (reset)
      err_count_ff <= rx_count_ff)
      else $error("error count exceeds rx count");
   a_tx_not_loop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |-> !rsp_loopback)
      else $error("tx byte sent in loopback");
   a_irq_out2: assert property (@(posedge clock) disable iff (reset)
      rsp_irq |-> mcr_ff[3])
      else $error("irq without OUT2");
`endif

endmodule
`default_nettype wire
